FILE: hdl/dfrr_pkg.sv
// Shared types and constants for the deficit round robin scheduler.
package dfrr_pkg;

  // Field widths fixed by the item format
  localparam int OP_W      = 1;
  localparam int CLASS_W   = 2;
  localparam int IN_LEN_W  = 14;
  localparam int OUT_LEN_W = 14;

  // Quantum register file
  localparam int NUM_QREGS = 4;
  localparam int QIDX_W    = 2;
  localparam int QUANTUM_W = 14;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 14'd1500;

  // Item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_VISIT,
    S_CHECK,
    S_STAY,
    S_DONE
  } state_t;

  // One result item
  typedef struct packed {
    logic                 grant_valid;
    logic [CLASS_W-1:0]   granted_class;
    logic [OUT_LEN_W-1:0] granted_length;
    logic                 enqueue_dropped;
  } res_t;

endpackage

FILE: hdl/deficit_round_robin_scheduler.sv
// Deficit round robin scheduler: class queues in one length memory, sequenced visits.
//
// Usage: the input channel (in_valid / in_stall) carries one item per request:
// an enqueue of a packet length into a class queue, or a dequeue request.
// Every item yields exactly one result item on the output channel
// (out_valid / out_stall): a drop flag for an enqueue, or a grant (class and
// length) for a dequeue; a dequeue with every queue empty yields no grant.
// Quantum registers are written through cfg_wr_en / cfg_index / cfg_wdata and reset
// to 1500 bytes; the user writes them only when idle; the block does not enforce it.
// Timing: the block works on one item at a time. An enqueue, or a dequeue with
// every queue empty, goes straight to S_DONE, which loads the output register; the
// next item is taken in S_IDLE after that. A dequeue steps through visits: a visit
// to an empty queue passes through S_VISIT only; a visit to a backlogged queue is
// S_VISIT (length memory read) then S_CHECK (the deficit compare); S_STAY does the
// stay check on the next head when the served queue still holds packets, and S_DONE
// loads the output register. The length memory read is registered, which is why a
// backlogged visit needs both a read state and a compare state.
// Reset (synchronous, rst_n low) empties all queues and clears deficits and
// the round pointer; the length memory itself is not cleared. While the
// receiver stalls, the finished result waits in the output register and a
// second result waits in the block; a third item is not taken until then.
module deficit_round_robin_scheduler #(
  parameter int NUM_CLASSES = 4,
  parameter int QUEUE_DEPTH = 64,
  parameter int LENGTH_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [dfrr_pkg::QIDX_W-1:0]       cfg_index,
  input  logic [dfrr_pkg::QUANTUM_W-1:0]    cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dfrr_pkg::OP_W-1:0]         in_operation,
  input  logic [dfrr_pkg::CLASS_W-1:0]      in_class_index,
  input  logic [dfrr_pkg::IN_LEN_W-1:0]     in_packet_length,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_grant_valid,
  output logic [dfrr_pkg::CLASS_W-1:0]      out_granted_class,
  output logic [dfrr_pkg::OUT_LEN_W-1:0]    out_granted_length,
  output logic                              out_enqueue_dropped
);

  localparam int PTR_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int HEAD_W    = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int TOTAL_W   = $clog2(MEM_DEPTH + 1);
  localparam int DEF_W     = ((LENGTH_BITS > dfrr_pkg::QUANTUM_W) ?
                              LENGTH_BITS : dfrr_pkg::QUANTUM_W) + 1;
  localparam int QIDX_W    = dfrr_pkg::QIDX_W;
  localparam int CLASS_W   = dfrr_pkg::CLASS_W;
  localparam int OUT_LEN_W = dfrr_pkg::OUT_LEN_W;

  // ring position after pos
  function automatic logic [HEAD_W-1:0] ring_next(input logic [HEAD_W-1:0] pos);
    logic [HEAD_W-1:0] res;
    if (32'(pos) == QUEUE_DEPTH - 1) res = '0;
    else                             res = pos + 1'b1;
    return res;
  endfunction

  // flat memory address of a class slot
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [PTR_W-1:0]  cls,
                                                 input logic [HEAD_W-1:0] slot);
    return ADDR_W'(32'(cls) * QUEUE_DEPTH + 32'(slot));
  endfunction

  // control state
  dfrr_pkg::state_t state_r, state_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic               qgiven_r, qgiven_nxt;
  logic [HEAD_W-1:0]  head_r    [NUM_CLASSES];
  logic [HEAD_W-1:0]  head_nxt  [NUM_CLASSES];
  logic [HEAD_W-1:0]  tail_r    [NUM_CLASSES];
  logic [HEAD_W-1:0]  tail_nxt  [NUM_CLASSES];
  logic [COUNT_W-1:0] count_r   [NUM_CLASSES];
  logic [COUNT_W-1:0] count_nxt [NUM_CLASSES];
  logic [DEF_W-1:0]   deficit_r   [NUM_CLASSES];
  logic [DEF_W-1:0]   deficit_nxt [NUM_CLASSES];
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [dfrr_pkg::QUANTUM_W-1:0] quantum_r [dfrr_pkg::NUM_QREGS];
  logic               out_valid_r, out_valid_nxt;

  // payload state
  dfrr_pkg::res_t     res_r, res_nxt;
  dfrr_pkg::res_t     out_r;
  logic [LENGTH_BITS-1:0] len_mem [MEM_DEPTH];
  logic [LENGTH_BITS-1:0] rd_data_r;

  // decoded signals
  logic                   in_acc;
  logic                   out_free;
  logic                   out_load;
  logic [PTR_W-1:0]       cls_idx;
  logic                   enq_drop;
  logic [LENGTH_BITS-1:0] in_len;
  logic [COUNT_W-1:0]     cur_count;
  logic [DEF_W-1:0]       cur_def;
  logic [HEAD_W-1:0]      cur_head;
  logic [HEAD_W-1:0]      next_head;
  logic [DEF_W-1:0]       head_len;
  logic                   ptr_last;
  logic [dfrr_pkg::QUANTUM_W-1:0] q_raw;
  logic [dfrr_pkg::QUANTUM_W-1:0] q_eff;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_wr_addr;
  logic [ADDR_W-1:0]      mem_rd_addr;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cls_idx   = PTR_W'(in_class_index);
  assign in_len    = LENGTH_BITS'(in_packet_length);
  assign enq_drop  = (32'(in_class_index) >= NUM_CLASSES) ||
                     (32'(count_r[cls_idx]) >= QUEUE_DEPTH);
  assign cur_count = count_r[ptr_r];
  assign cur_def   = deficit_r[ptr_r];
  assign cur_head  = head_r[ptr_r];
  assign next_head = ring_next(cur_head);
  assign head_len  = DEF_W'(rd_data_r);
  assign ptr_last  = (32'(ptr_r) == NUM_CLASSES - 1);

  // quantum of the visited class; zero acts as one
  always_comb begin
    if (32'(ptr_r) < dfrr_pkg::NUM_QREGS) q_raw = quantum_r[QIDX_W'(ptr_r)];
    else                                  q_raw = dfrr_pkg::QUANTUM_RESET;
    q_eff = (q_raw == '0) ? dfrr_pkg::QUANTUM_W'(1) : q_raw;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dfrr_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_operation == dfrr_pkg::OP_ENQ || total_r == '0) begin
            state_nxt = dfrr_pkg::S_DONE;
          end else begin
            state_nxt = dfrr_pkg::S_VISIT;
          end
        end
      end
      dfrr_pkg::S_VISIT: begin
        if (cur_count != '0) state_nxt = dfrr_pkg::S_CHECK;
      end
      dfrr_pkg::S_CHECK: begin
        if (cur_def < head_len)                 state_nxt = dfrr_pkg::S_VISIT;
        else if (cur_count == COUNT_W'(1))      state_nxt = dfrr_pkg::S_DONE;
        else                                    state_nxt = dfrr_pkg::S_STAY;
      end
      dfrr_pkg::S_STAY: begin
        state_nxt = dfrr_pkg::S_DONE;
      end
      dfrr_pkg::S_DONE: begin
        if (out_free) state_nxt = dfrr_pkg::S_IDLE;
      end
      default: state_nxt = dfrr_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: handshake, output load, memory read address
  always_comb begin
    in_stall    = (state_r != dfrr_pkg::S_IDLE);
    out_load    = (state_r == dfrr_pkg::S_DONE) && out_free;
    mem_rd_addr = mem_addr(ptr_r, cur_head);
    if (state_r == dfrr_pkg::S_CHECK) mem_rd_addr = mem_addr(ptr_r, next_head);
  end

  // queue and deficit update
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    deficit_nxt = deficit_r;
    total_nxt   = total_r;
    ptr_nxt     = ptr_r;
    qgiven_nxt  = qgiven_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_wr_addr = mem_addr(cls_idx, tail_r[cls_idx]);
    case (state_r)
      dfrr_pkg::S_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          if (in_operation == dfrr_pkg::OP_ENQ) begin
            if (enq_drop) begin
              res_nxt.enqueue_dropped = 1'b1;
            end else begin
              mem_we             = 1'b1;
              tail_nxt[cls_idx]  = ring_next(tail_r[cls_idx]);
              count_nxt[cls_idx] = count_r[cls_idx] + 1'b1;
              total_nxt          = total_r + 1'b1;
            end
          end else if (total_r == '0) begin
            // nothing backlogged: clear all credit
            for (int i = 0; i < NUM_CLASSES; i++) deficit_nxt[i] = '0;
            qgiven_nxt = 1'b0;
          end
        end
      end
      dfrr_pkg::S_VISIT: begin
        if (cur_count == '0) begin
          deficit_nxt[ptr_r] = '0;
          ptr_nxt            = ptr_last ? '0 : ptr_r + 1'b1;
          qgiven_nxt         = 1'b0;
        end else if (!qgiven_r) begin
          deficit_nxt[ptr_r] = cur_def + DEF_W'(q_eff);
          qgiven_nxt         = 1'b1;
        end
      end
      dfrr_pkg::S_CHECK: begin
        if (cur_def < head_len) begin
          ptr_nxt    = ptr_last ? '0 : ptr_r + 1'b1;
          qgiven_nxt = 1'b0;
        end else begin
          // serve the head packet
          deficit_nxt[ptr_r]     = cur_def - head_len;
          head_nxt[ptr_r]        = next_head;
          count_nxt[ptr_r]       = cur_count - 1'b1;
          total_nxt              = total_r - 1'b1;
          res_nxt.grant_valid    = 1'b1;
          res_nxt.granted_class  = CLASS_W'(ptr_r);
          res_nxt.granted_length = OUT_LEN_W'(rd_data_r);
          if (cur_count == COUNT_W'(1)) begin
            deficit_nxt[ptr_r] = '0;
            ptr_nxt            = ptr_last ? '0 : ptr_r + 1'b1;
            qgiven_nxt         = 1'b0;
          end
        end
      end
      dfrr_pkg::S_STAY: begin
        // move on unless the credit left covers the new head
        if (cur_def < head_len) begin
          ptr_nxt    = ptr_last ? '0 : ptr_r + 1'b1;
          qgiven_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) out_valid_nxt = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfrr_pkg::S_IDLE;
      ptr_r       <= '0;
      qgiven_r    <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i]    <= '0;
        tail_r[i]    <= '0;
        count_r[i]   <= '0;
        deficit_r[i] <= '0;
      end
      for (int i = 0; i < dfrr_pkg::NUM_QREGS; i++) begin
        quantum_r[i] <= dfrr_pkg::QUANTUM_RESET;
      end
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      qgiven_r    <= qgiven_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      deficit_r   <= deficit_nxt;
      if (cfg_wr_en) quantum_r[cfg_index] <= cfg_wdata;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (out_load) out_r <= res_r;
  end

  // packet length memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) len_mem[mem_wr_addr] <= in_len;
    rd_data_r <= len_mem[mem_rd_addr];
  end

  assign out_valid           = out_valid_r;
  assign out_grant_valid     = out_r.grant_valid;
  assign out_granted_class   = out_r.granted_class;
  assign out_granted_length  = out_r.granted_length;
  assign out_enqueue_dropped = out_r.enqueue_dropped;

  // a compare always follows the visit that issued its memory read
  a_check_after_visit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dfrr_pkg::S_CHECK |-> $past(state_r) == dfrr_pkg::S_VISIT)
    else $error("compare without a preceding visit");

  // the compared queue is backlogged and has received its quantum
  a_check_backlogged: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dfrr_pkg::S_CHECK |-> cur_count != '0 && qgiven_r)
    else $error("compare on an empty or uncredited queue");

  // the visit loop only runs while some packet is queued
  a_visit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dfrr_pkg::S_VISIT |-> total_r != '0)
    else $error("visit loop with no backlog");

  // a grant and a drop never come together
  a_grant_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_grant_valid |-> !out_enqueue_dropped)
    else $error("grant flagged as drop");

  // the output register is loaded only when it is free
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || !out_stall)
    else $error("output register overwritten");

endmodule
